// File: hdl/bpm_pkg.sv
`default_nettype none

package bpm_pkg;

  // default depths
  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned PairDepthDef  = 256;

  // field widths
  localparam int unsigned OP_W  = 2;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned ROW_W = 16;
  localparam int unsigned COL_W = 12;
  localparam int unsigned STS_W = 4;
  localparam int unsigned LOC_W = ROW_W + COL_W;

  // bracket characters
  localparam logic [SYM_W-1:0] CHAR_OPEN  = 8'h5B;
  localparam logic [SYM_W-1:0] CHAR_CLOSE = 8'h5D;

  // request operations
  typedef enum logic [OP_W-1:0] {
    OP_SYMBOL = 2'd0,
    OP_END    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [STS_W-1:0] {
    STS_IGNORED         = 4'd0,
    STS_OPENED          = 4'd1,
    STS_PAIRED          = 4'd2,
    STS_UNMATCHED_CLOSE = 4'd3,
    STS_UNMATCHED_OPEN  = 4'd4,
    STS_FOUND           = 4'd5,
    STS_NOT_FOUND       = 4'd6,
    STS_OVERFLOW        = 4'd7,
    STS_HALTED          = 4'd8,
    STS_END_OK          = 4'd9,
    STS_CLEARED         = 4'd10
  } status_e;

  // location is row above column
  typedef logic [LOC_W-1:0] loc_t;

  // one recorded bracket pair
  typedef struct packed {
    loc_t left;
    loc_t right;
  } pair_t;

  // search start from the sequencer
  typedef struct packed {
    logic start;
    logic left_side;
    loc_t key;
  } scan_req_t;

  // search outcome back to the sequencer
  typedef struct packed {
    logic done;
    logic found;
    loc_t partner;
  } scan_rsp_t;

endpackage

`default_nettype wire

// File: hdl/bpm_req_if.sv
`default_nettype none

interface bpm_req_if;
  import bpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [SYM_W-1:0] symbol;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;

  modport source (output valid, output op, output symbol, output row, output col,
                  input ready);
  modport sink   (input valid, input op, input symbol, input row, input col,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/bpm_rsp_if.sv
`default_nettype none

interface bpm_rsp_if;
  import bpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [ROW_W-1:0] row_out;
  logic [COL_W-1:0] col_out;

  modport source (output valid, output status, output row_out, output col_out,
                  input ready);
  modport sink   (input valid, input status, input row_out, input col_out,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/bracket_pair_matcher_top.sv
`default_nettype none

// Bracket pair matcher.
// req_i takes requests: symbol, end of program, lookup and clear, each with a
// location (row, col). rsp_o gives exactly one result per request, in order.
// A '[' pushes its location; a ']' pops the newest opener and records the pair.
// Lookup searches recorded pairs, oldest first, one entry a cycle through a
// single shared comparator on the pair memory read port.
// Clear, halted, ignored, '[' and all errors detected up front are written to
// the result register as the request is taken; a matched ']' and end of
// program with openers left first pass through ST_POP or ST_END (stack memory
// read); a lookup waits in ST_SCAN until the search hits or has read all
// pair_count entries, and ends without reading when the table is empty.
// One request is in flight at a time; req_i.ready drops while it is worked.
// The result register frees req_i from rsp_o: a new request is taken while
// the previous result is being taken in the same cycle.
// If the receiver stalls, the result holds and no new request is taken.
// Reset empties the stack and pair table counts and clears the error latch;
// memory contents need no clearing.

module bracket_pair_matcher_top #(
  parameter int unsigned STACK_DEPTH = bpm_pkg::StackDepthDef,
  parameter int unsigned PAIR_DEPTH  = bpm_pkg::PairDepthDef
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  bpm_req_if.sink      req_i,
  bpm_rsp_if.source    rsp_o
);
  import bpm_pkg::*;

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SIW = $clog2(STACK_DEPTH);
  localparam int unsigned PCW = $clog2(PAIR_DEPTH + 1);
  localparam int unsigned PIW = $clog2(PAIR_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_END,
    ST_SCAN
  } state_e;

  state_e          state_q;
  logic [SPW-1:0]  sp_q;
  logic [PCW-1:0]  pc_q;
  logic            err_q;
  loc_t            loc_q;
  logic            rsp_valid_q;
  status_e         status_q;
  loc_t            res_loc_q;

  loc_t            stack_q [STACK_DEPTH];
  loc_t            top_q;

  logic            accept;
  logic            push;
  logic            sp_full;
  logic            pc_full;
  logic [SPW-1:0]  sp_dec;
  loc_t            in_loc;
  op_e             in_op;
  scan_req_t       scan_req;
  scan_rsp_t       scan_rsp;
  pair_t           wr_pair;

  // request handshake
  assign req_i.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign in_loc      = {req_i.row, req_i.col};
  assign in_op       = op_e'(req_i.op);

  // stack and table bounds
  assign sp_full = (sp_q == SPW'(STACK_DEPTH));
  assign pc_full = (pc_q == PCW'(PAIR_DEPTH));
  assign sp_dec  = sp_q - SPW'(1);
  assign push    = accept && !err_q && (in_op == OP_SYMBOL) &&
                   (req_i.symbol == CHAR_OPEN) && !sp_full;

  // lookup start
  assign scan_req.start     = accept && !err_q && (in_op == OP_LOOKUP);
  assign scan_req.left_side = (req_i.symbol == CHAR_OPEN);
  assign scan_req.key       = in_loc;

  assign wr_pair.left  = top_q;
  assign wr_pair.right = loc_q;

  bpm_pair_table #(
    .PAIR_DEPTH (PAIR_DEPTH)
  ) u_pair_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .scan_i    (scan_req),
    .count_i   (pc_q),
    .wr_en_i   (state_q == ST_POP),
    .wr_addr_i (pc_q[PIW-1:0]),
    .wr_data_i (wr_pair),
    .scan_o    (scan_rsp)
  );

  // opener stack, top entry read every cycle
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[sp_q[SIW-1:0]] <= in_loc;
    end
    top_q <= stack_q[sp_dec[SIW-1:0]];
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sp_q        <= '0;
      pc_q        <= '0;
      err_q       <= 1'b0;
      loc_q       <= '0;
      rsp_valid_q <= 1'b0;
      status_q    <= STS_IGNORED;
      res_loc_q   <= '0;
    end else begin
      if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            loc_q       <= in_loc;
            rsp_valid_q <= 1'b1;
            res_loc_q   <= '0;
            if (in_op == OP_CLEAR) begin
              sp_q     <= '0;
              pc_q     <= '0;
              err_q    <= 1'b0;
              status_q <= STS_CLEARED;
            end else if (err_q) begin
              status_q <= STS_HALTED;
            end else begin
              case (in_op)
                OP_SYMBOL: begin
                  if (req_i.symbol == CHAR_OPEN) begin
                    res_loc_q <= in_loc;
                    if (sp_full) begin
                      err_q    <= 1'b1;
                      status_q <= STS_OVERFLOW;
                    end else begin
                      sp_q     <= sp_q + SPW'(1);
                      status_q <= STS_OPENED;
                    end
                  end else if (req_i.symbol == CHAR_CLOSE) begin
                    res_loc_q <= in_loc;
                    if (sp_q == '0) begin
                      err_q    <= 1'b1;
                      status_q <= STS_UNMATCHED_CLOSE;
                    end else if (pc_full) begin
                      err_q    <= 1'b1;
                      status_q <= STS_OVERFLOW;
                    end else begin
                      rsp_valid_q <= 1'b0;
                      state_q     <= ST_POP;
                    end
                  end else begin
                    status_q <= STS_IGNORED;
                  end
                end
                OP_END: begin
                  if (sp_q != '0) begin
                    rsp_valid_q <= 1'b0;
                    state_q     <= ST_END;
                  end else begin
                    status_q <= STS_END_OK;
                  end
                end
                OP_LOOKUP: begin
                  rsp_valid_q <= 1'b0;
                  state_q     <= ST_SCAN;
                end
                default: begin
                  status_q <= STS_IGNORED;
                end
              endcase
            end
          end
        end
        // pop the newest opener and record the pair
        ST_POP: begin
          sp_q        <= sp_dec;
          pc_q        <= pc_q + PCW'(1);
          status_q    <= STS_PAIRED;
          res_loc_q   <= top_q;
          rsp_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        // report the newest unmatched opener
        ST_END: begin
          err_q       <= 1'b1;
          status_q    <= STS_UNMATCHED_OPEN;
          res_loc_q   <= top_q;
          rsp_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        // wait for the table search
        ST_SCAN: begin
          if (scan_rsp.done) begin
            status_q    <= scan_rsp.found ? STS_FOUND : STS_NOT_FOUND;
            res_loc_q   <= scan_rsp.found ? scan_rsp.partner : '0;
            rsp_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // result outputs
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.status  = status_q;
  assign rsp_o.row_out = res_loc_q[LOC_W-1:COL_W];
  assign rsp_o.col_out = res_loc_q[COL_W-1:0];

`ifndef SYNTHESIS
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_q <= SPW'(STACK_DEPTH)) && (pc_q <= PCW'(PAIR_DEPTH)))
    else $error("stack or pair count beyond depth");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_op == OP_CLEAR) |=>
      rsp_valid_q && (status_q == STS_CLEARED) && !err_q && (sp_q == '0) && (pc_q == '0))
    else $error("clear request did not empty the block");

  a_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && err_q && (in_op != OP_CLEAR) |=>
      rsp_valid_q && (status_q == STS_HALTED) && (state_q == ST_IDLE))
    else $error("latched error did not answer halted");

  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_rsp.done |-> (state_q == ST_SCAN) && !rsp_valid_q)
    else $error("search finished outside a lookup");
`endif

endmodule

`default_nettype wire

// File: hdl/bpm_pair_table.sv
`default_nettype none

module bpm_pair_table #(
  parameter int unsigned PAIR_DEPTH = bpm_pkg::PairDepthDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire bpm_pkg::scan_req_t                scan_i,
  input  wire logic [$clog2(PAIR_DEPTH+1)-1:0]   count_i,
  input  wire logic                              wr_en_i,
  input  wire logic [$clog2(PAIR_DEPTH)-1:0]     wr_addr_i,
  input  wire bpm_pkg::pair_t                    wr_data_i,
  output bpm_pkg::scan_rsp_t                     scan_o
);
  import bpm_pkg::*;

  localparam int unsigned CW = $clog2(PAIR_DEPTH + 1);
  localparam int unsigned IW = $clog2(PAIR_DEPTH);

  pair_t           mem_q [PAIR_DEPTH];
  pair_t           rd_data_q;
  logic            rd_valid_q;
  logic            busy_q;
  logic            left_side_q;
  loc_t            key_q;
  logic [CW-1:0]   idx_q;

  logic            hit;
  logic            done;
  logic            issue;
  loc_t            probe;

  // shared compare against the entry read last cycle
  assign probe = left_side_q ? rd_data_q.left : rd_data_q.right;
  assign hit   = rd_valid_q && (probe == key_q);
  assign done  = busy_q && (hit || (!rd_valid_q && (idx_q == count_i)));
  assign issue = busy_q && !done && (idx_q != count_i);

  assign scan_o.done    = done;
  assign scan_o.found   = hit;
  assign scan_o.partner = left_side_q ? rd_data_q.right : rd_data_q.left;

  // scan sequencer, oldest entry first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rd_valid_q  <= 1'b0;
      idx_q       <= '0;
      left_side_q <= 1'b0;
      key_q       <= '0;
    end else if (scan_i.start) begin
      busy_q      <= 1'b1;
      rd_valid_q  <= 1'b0;
      idx_q       <= '0;
      left_side_q <= scan_i.left_side;
      key_q       <= scan_i.key;
    end else if (done) begin
      busy_q     <= 1'b0;
      rd_valid_q <= 1'b0;
    end else if (busy_q) begin
      rd_valid_q <= issue;
      if (issue) begin
        idx_q <= idx_q + CW'(1);
      end
    end
  end

  // pair memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[idx_q[IW-1:0]];
  end

endmodule

`default_nettype wire
